### hdl/tpre_pkg.sv
// shared types, codes and arithmetic helpers of the toll pricing revenue evaluator
// no dependencies
package tpre_pkg;

    localparam logic signed [31:0] START_COST_RST = 32'sd25600000;

    typedef enum logic [1:0] {
        K_LOAD = 2'd0,
        K_COST = 2'd1,
        K_EVAL = 2'd2,
        K_READ = 2'd3
    } t_kind;

    localparam logic RES_EVAL = 1'b0;
    localparam logic RES_BEST = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_RMUL,
        S_RADD,
        S_EVAL,
        S_COPY,
        S_BEST
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic               in_range;
        logic [5:0]         idx;
        logic signed [31:0] price;
        logic signed [31:0] coef;
        logic signed [31:0] tcost;
        logic signed [31:0] tfree;
        logic [15:0]        users;
        logic               last;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    // floor(p / 256) saturated to 32 bits
    function automatic logic signed [31:0] sat_charge(input logic signed [63:0] p);
        logic fits;
        fits = (p[63:39] == {25{1'b0}}) || (p[63:39] == {25{1'b1}});
        if (fits) begin
            sat_charge = p[39:8];
        end else if (p[63]) begin
            sat_charge = 32'sh8000_0000;
        end else begin
            sat_charge = 32'sh7FFF_FFFF;
        end
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            sat_add64 = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end else begin
            sat_add64 = s;
        end
    endfunction

endpackage

### hdl/tpre_front.sv
// front part: takes commands, decodes kind and index range, queues them for the back part
// depends on tpre_pkg
module tpre_front #(
    parameter int MAX_TOLLS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_kind,
    input  logic [5:0]          i_toll_index,
    input  logic signed [31:0]  i_price,
    input  logic signed [31:0]  i_coefficient,
    input  logic signed [31:0]  i_transfer_cost,
    input  logic signed [31:0]  i_tax_free_cost,
    input  logic [15:0]         i_users,
    input  logic                i_last_toll,
    output logic                o_busy,
    output tpre_pkg::t_head     o_head,
    input  logic                i_pop
);

    tpre_pkg::t_item r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    tpre_pkg::t_item w_item;
    logic            w_push;

    always_comb begin
        w_item.kind     = tpre_pkg::t_kind'(i_kind);
        w_item.in_range = (32'(i_toll_index) < MAX_TOLLS);
        w_item.idx      = i_toll_index;
        w_item.price    = i_price;
        w_item.coef     = i_coefficient;
        w_item.tcost    = i_transfer_cost;
        w_item.tfree    = i_tax_free_cost;
        w_item.users    = i_users;
        w_item.last     = i_last_toll;
    end

    assign o_busy      = (r_cnt == 2'd2);
    assign w_push      = i_start && !o_busy;
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

endmodule

### hdl/tpre_back.sv
// back part: toll memories, cheapest path search, revenue sum, best price snapshot
// depends on tpre_pkg
module tpre_back #(
    parameter int MAX_TOLLS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tpre_pkg::t_head     i_head,
    output logic                o_pop,
    input  logic signed [31:0]  i_start_cost,
    output logic                o_valid,
    output logic                o_result_kind,
    output logic signed [63:0]  o_revenue,
    output logic                o_improved,
    output logic signed [63:0]  o_best_revenue,
    output logic signed [31:0]  o_best_price
);

    localparam int AW = (MAX_TOLLS > 1) ? $clog2(MAX_TOLLS) : 1;
    localparam int CW = $clog2(MAX_TOLLS + 1);

    logic signed [31:0] m_price [MAX_TOLLS];
    logic signed [31:0] m_coef  [MAX_TOLLS];
    logic signed [31:0] m_best  [MAX_TOLLS];

    tpre_pkg::t_state   r_state, n_state;
    tpre_pkg::t_item    r_item;
    logic signed [31:0] r_prd, r_crd, r_brd;
    logic signed [63:0] r_prod;
    logic signed [33:0] r_min_cost;
    logic signed [31:0] r_min_charge;
    logic               r_path;
    logic signed [47:0] r_term;
    logic               r_take;
    logic signed [63:0] r_rev, r_best_rev;
    logic               r_copied;
    logic [CW-1:0]      r_cnt;

    logic [AW-1:0]      w_head_addr, w_rd_addr, w_cp_addr;
    logic               w_load_we, w_copy_we, w_copy_done;
    logic signed [31:0] w_charge;
    logic signed [33:0] w_cost;
    logic               w_better_path, w_better_rev;

    assign w_head_addr = AW'(i_head.item.idx);
    assign w_cp_addr   = AW'(r_cnt - CW'(1));
    assign w_rd_addr   = (r_state == tpre_pkg::S_COPY) ? AW'(r_cnt) : w_head_addr;
    assign w_copy_done = (r_cnt == CW'(MAX_TOLLS));

    // cheapest path compare
    always_comb begin
        w_charge = r_item.in_range ? tpre_pkg::sat_charge(r_prod) : 32'sd0;
        w_cost   = 34'(w_charge) + 34'(r_item.tcost);
        if (!r_path) begin
            w_better_path = (w_cost <= 34'(i_start_cost));
        end else begin
            w_better_path = (w_cost < r_min_cost) ||
                            (w_cost == r_min_cost && w_charge > r_min_charge);
        end
    end

    assign w_better_rev = (r_rev > r_best_rev);

    always_comb begin
        n_state = r_state;
        case (r_state)
            tpre_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    case (i_head.item.kind)
                        tpre_pkg::K_LOAD: n_state = tpre_pkg::S_IDLE;
                        tpre_pkg::K_COST: n_state = tpre_pkg::S_MUL;
                        tpre_pkg::K_EVAL: n_state = tpre_pkg::S_EVAL;
                        tpre_pkg::K_READ: n_state = tpre_pkg::S_BEST;
                        default:          n_state = tpre_pkg::S_IDLE;
                    endcase
                end
            end
            tpre_pkg::S_MUL:  n_state = tpre_pkg::S_CMP;
            tpre_pkg::S_CMP:  n_state = r_item.last ? tpre_pkg::S_RMUL : tpre_pkg::S_IDLE;
            tpre_pkg::S_RMUL: n_state = tpre_pkg::S_RADD;
            tpre_pkg::S_RADD: n_state = tpre_pkg::S_IDLE;
            tpre_pkg::S_EVAL: n_state = w_better_rev ? tpre_pkg::S_COPY : tpre_pkg::S_IDLE;
            tpre_pkg::S_COPY: n_state = w_copy_done ? tpre_pkg::S_IDLE : tpre_pkg::S_COPY;
            tpre_pkg::S_BEST: n_state = tpre_pkg::S_IDLE;
            default:          n_state = tpre_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == tpre_pkg::S_IDLE) && i_head.valid;
        w_load_we = o_pop && (i_head.item.kind == tpre_pkg::K_LOAD) && i_head.item.in_range;
        w_copy_we = (r_state == tpre_pkg::S_COPY) && (r_cnt != CW'(0));
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            m_price[w_head_addr] <= i_head.item.price;
            m_coef[w_head_addr]  <= i_head.item.coef;
        end
        r_prd <= m_price[w_rd_addr];
        r_crd <= m_coef[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_copy_we) begin
            m_best[w_cp_addr] <= r_prd;
        end
        r_brd <= m_best[w_head_addr];
    end

    // datapath without reset
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head.item;
        end
        r_prod <= r_prd * r_crd;
        r_term <= r_min_charge * $signed({1'b0, r_item.users});
        r_take <= r_path && (34'(r_item.tfree) >= r_min_cost);
        if (r_state == tpre_pkg::S_CMP && w_better_path) begin
            r_min_cost   <= w_cost;
            r_min_charge <= w_charge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= tpre_pkg::S_IDLE;
            r_path         <= 1'b0;
            r_rev          <= 64'sd0;
            r_best_rev     <= 64'sd0;
            r_copied       <= 1'b0;
            r_cnt          <= '0;
            o_valid        <= 1'b0;
            o_result_kind  <= tpre_pkg::RES_EVAL;
            o_revenue      <= 64'sd0;
            o_improved     <= 1'b0;
            o_best_revenue <= 64'sd0;
            o_best_price   <= 32'sd0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            case (r_state)
                tpre_pkg::S_CMP: begin
                    if (w_better_path) begin
                        r_path <= 1'b1;
                    end
                end
                tpre_pkg::S_RADD: begin
                    if (r_take) begin
                        r_rev <= tpre_pkg::sat_add64(r_rev, 64'(r_term));
                    end
                    r_path <= 1'b0;
                end
                tpre_pkg::S_EVAL: begin
                    o_valid        <= 1'b1;
                    o_result_kind  <= tpre_pkg::RES_EVAL;
                    o_revenue      <= r_rev;
                    o_improved     <= w_better_rev;
                    o_best_revenue <= w_better_rev ? r_rev : r_best_rev;
                    o_best_price   <= 32'sd0;
                    if (w_better_rev) begin
                        r_best_rev <= r_rev;
                    end
                    r_rev  <= 64'sd0;
                    r_path <= 1'b0;
                    r_cnt  <= '0;
                end
                tpre_pkg::S_COPY: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (w_copy_done) begin
                        r_copied <= 1'b1;
                    end
                end
                tpre_pkg::S_BEST: begin
                    o_valid        <= 1'b1;
                    o_result_kind  <= tpre_pkg::RES_BEST;
                    o_revenue      <= 64'sd0;
                    o_improved     <= 1'b0;
                    o_best_revenue <= r_best_rev;
                    // the snapshot reads as zero until the first improvement
                    o_best_price   <= (r_item.in_range && r_copied) ? r_brd : 32'sd0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### hdl/toll_pricing_revenue_eval.sv
// top level of the toll pricing revenue evaluator: apb register, front queue and back part
// depends on tpre_pkg, tpre_front, tpre_back
//
// A command is taken when start is high and busy is low. A load is written in the back part
// straight from the queue head. A cost entry passes memory read, 32x32 multiply and compare,
// and on a commodity's last toll also charge times users and a saturating add. An end of
// evaluation compares the revenue and, when it improves, copies all prices one entry a cycle
// into the best price store. A best price read returns the stored price. A two-entry queue sits in
// front, so busy rises only when it is full. Results appear for one cycle with o_valid and
// cannot be held off.
module toll_pricing_revenue_eval #(
    parameter int MAX_TOLLS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_kind,
    input  logic [5:0]          i_toll_index,
    input  logic signed [31:0]  i_price,
    input  logic signed [31:0]  i_coefficient,
    input  logic signed [31:0]  i_transfer_cost,
    input  logic signed [31:0]  i_tax_free_cost,
    input  logic [15:0]         i_users,
    input  logic                i_last_toll,
    output logic                o_valid,
    output logic                o_result_kind,
    output logic signed [63:0]  o_revenue,
    output logic                o_improved,
    output logic signed [63:0]  o_best_revenue,
    output logic signed [31:0]  o_best_price
);

    logic signed [31:0] r_start_cost;
    tpre_pkg::t_head    w_head;
    logic               w_pop;
    logic               w_unused_addr;

    assign pready        = 1'b1;
    assign prdata        = r_start_cost;
    assign w_unused_addr = ^paddr;

    // single register, every word address maps onto it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_cost <= tpre_pkg::START_COST_RST;
        end else if (psel && penable && pwrite && pready && (w_unused_addr || !w_unused_addr)) begin
            r_start_cost <= pwdata;
        end
    end

    tpre_front #(.MAX_TOLLS(MAX_TOLLS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_kind          (i_kind),
        .i_toll_index    (i_toll_index),
        .i_price         (i_price),
        .i_coefficient   (i_coefficient),
        .i_transfer_cost (i_transfer_cost),
        .i_tax_free_cost (i_tax_free_cost),
        .i_users         (i_users),
        .i_last_toll     (i_last_toll),
        .o_busy          (busy),
        .o_head          (w_head),
        .i_pop           (w_pop)
    );

    tpre_back #(.MAX_TOLLS(MAX_TOLLS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .i_start_cost   (r_start_cost),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_revenue      (o_revenue),
        .o_improved     (o_improved),
        .o_best_revenue (o_best_revenue),
        .o_best_price   (o_best_price)
    );

    a_no_adjacent_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("results in adjacent cycles");

    a_best_answer_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == tpre_pkg::RES_BEST) |-> (o_revenue == 64'sd0 && !o_improved))
        else $error("best price answer carries revenue fields");

    a_improved_tracks_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_improved) |-> (o_best_revenue == o_revenue))
        else $error("improvement without best revenue update");

endmodule
